// ===== rtl/core/escape_chain_text_encoder_top_assert.svh =====
// Assertion shorthands shared by the encoder RTL.
`ifndef ESCAPE_CHAIN_TEXT_ENCODER_TOP_ASSERT_SVH
`define ESCAPE_CHAIN_TEXT_ENCODER_TOP_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define ECTX_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ECTX_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ECTX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ectx_pkg.sv =====
`default_nettype none
package ectx_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_UNDER = 8'd95;
  localparam logic [7:0] CH_N     = 8'd110;
  localparam logic [7:0] CH_U     = 8'd117;

  localparam logic [7:0] FIRST_OFFSET = 8'd2;

  // Configuration registers
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_SPACE_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_LENGTH     = 1'd1;
  localparam logic [11:0] THRESHOLD_RESET   = 12'd800;
  localparam logic [7:0]  LINE_LENGTH_RESET = 8'd80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_message;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } result_t;

  // One classified item: one or two padded bytes plus the message-start mark.
  typedef struct packed {
    logic [7:0] pad0;
    logic [7:0] pad1;
    logic       two;
    logic       clear;
  } pad_entry_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic       valid;
    pad_entry_t entry;
  } queue_head_t;

endpackage
`default_nettype wire

// ===== rtl/core/ectx_front.sv =====
`default_nettype none
module ectx_front import ectx_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         item_valid,
  output logic        item_stall,
  input  item_t       item_data,
  input  wire         queue_full,
  output logic        push,
  output pad_entry_t  push_entry
);

  always_comb begin
    push_entry.clear = item_data.first_of_message;
    push_entry.two   = 1'b1;
    push_entry.pad0  = ~CH_UNDER;
    push_entry.pad1  = 8'd0;
    priority if (item_data.data_byte == CH_SPACE) begin
      push_entry.pad1 = ~CH_UNDER;
    end else if (item_data.data_byte == CH_LF) begin
      push_entry.pad1 = ~CH_N;
    end else if (item_data.data_byte == CH_UNDER) begin
      push_entry.pad1 = ~CH_U;
    end else begin
      push_entry.pad0 = ~item_data.data_byte;
      push_entry.two  = 1'b0;
    end
  end

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

`include "escape_chain_text_encoder_top_assert.svh"

  `ECTX_ASSERT_IMPLIES(a_push_needs_room, clk, rst, push, !queue_full, "push into full queue")

endmodule
`default_nettype wire

// ===== rtl/core/ectx_queue.sv =====
`default_nettype none
module ectx_queue import ectx_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          push,
  input  pad_entry_t   push_entry,
  input  wire          pop,
  output logic         full,
  output queue_head_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pad_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`include "escape_chain_text_encoder_top_assert.svh"

  `ECTX_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue count overflow")
  `ECTX_ASSERT_IMPLIES(a_pop_nonempty, clk, rst, pop, head.valid, "pop from empty queue")

endmodule
`default_nettype wire

// ===== rtl/core/ectx_back.sv =====
`default_nettype none
module ectx_back import ectx_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  queue_head_t  head,
  output logic         pop,
  input  wire  [11:0]  space_threshold,
  input  wire  [7:0]   line_length,
  output logic         result_valid,
  input  wire          result_stall,
  output result_t      result_data
);

  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_SPACE = 2'd1;
  localparam logic [1:0] PH_LF    = 2'd2;

  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic        lf_pend;
  logic        lf_pend_next;
  logic        pidx;
  logic [7:0]  previous_code;
  logic        awaiting_first;
  logic [12:0] value_sum;
  logic [7:0]  column_count;

  logic        adv;
  logic        use_clear;
  logic [7:0]  cur_pad;
  logic [7:0]  eff_prev;
  logic        eff_await;
  logic [12:0] eff_sum;
  logic [7:0]  eff_col;
  logic [7:0]  code;
  logic [7:0]  diff;
  logic [7:0]  total;
  logic [12:0] sum_new;
  logic        space_hit;
  logic [7:0]  col_one;
  logic        lf_hit;
  logic [7:0]  col_final;
  logic        last_pad;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        pad_done;

  assign adv       = head.valid && (!result_valid || !result_stall);
  assign use_clear = head.entry.clear && !pidx;
  assign cur_pad   = pidx ? head.entry.pad1 : head.entry.pad0;
  assign last_pad  = !head.entry.two || pidx;

  assign eff_prev  = use_clear ? 8'd0  : previous_code;
  assign eff_await = use_clear ? 1'b1  : awaiting_first;
  assign eff_sum   = use_clear ? 13'd0 : value_sum;
  assign eff_col   = use_clear ? 8'd0  : column_count;

  // Chain the padded byte to the previous code.
  assign diff  = cur_pad - eff_prev;
  assign total = cur_pad + eff_prev;
  always_comb begin
    priority if (eff_await) begin
      code = cur_pad + FIRST_OFFSET;
    end else if (cur_pad[7]) begin
      code = {1'b1, diff[6:0]};
    end else begin
      code = {1'b0, total[6:0]};
    end
  end

  assign sum_new   = eff_sum + {5'd0, code};
  assign space_hit = (sum_new >= {1'b0, space_threshold});
  assign col_one   = eff_col + {7'd0, space_hit};
  assign lf_hit    = (col_one >= line_length);
  assign col_final = (lf_hit ? 8'd0 : col_one) + 8'd1;

  always_comb begin
    phase_next   = PH_CODE;
    lf_pend_next = 1'b0;
    emit         = 1'b1;
    emit_byte    = code;
    emit_last    = 1'b0;
    pad_done     = 1'b0;
    unique case (phase)
      PH_CODE: begin
        emit_byte = code;
        if (space_hit) begin
          phase_next   = PH_SPACE;
          lf_pend_next = lf_hit;
        end else if (lf_hit) begin
          phase_next = PH_LF;
        end else begin
          pad_done = 1'b1;
        end
        emit_last = !space_hit && !lf_hit && last_pad;
      end
      PH_SPACE: begin
        emit_byte = CH_SPACE;
        if (lf_pend) begin
          phase_next = PH_LF;
        end else begin
          pad_done  = 1'b1;
          emit_last = last_pad;
        end
      end
      PH_LF: begin
        emit_byte = CH_LF;
        pad_done  = 1'b1;
        emit_last = last_pad;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign pop = adv && pad_done && last_pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CODE;
      lf_pend        <= 1'b0;
      pidx           <= 1'b0;
      previous_code  <= 8'd0;
      awaiting_first <= 1'b1;
      value_sum      <= 13'd0;
      column_count   <= 8'd0;
      result_valid   <= 1'b0;
    end else begin
      if (adv) begin
        phase   <= phase_next;
        lf_pend <= lf_pend_next;
        if (pad_done) begin
          pidx <= !last_pad;
        end
        if (phase == PH_CODE) begin
          previous_code  <= code;
          awaiting_first <= 1'b0;
          value_sum      <= space_hit ? 13'd0 : sum_new;
          column_count   <= col_final;
        end
      end
      if (adv && emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      result_data.out_byte    <= emit_byte;
      result_data.last_of_run <= emit_last;
    end
  end

`include "escape_chain_text_encoder_top_assert.svh"

  `ECTX_ASSERT_IMPLIES(a_mid_item_has_head, clk, rst, phase != PH_CODE, head.valid, "mid-item without queue head")
  `ECTX_ASSERT_IMPLIES(a_mid_item_has_result, clk, rst, phase != PH_CODE, result_valid, "pending insert without held result")
  `ECTX_ASSERT_NEXT(a_taken_result_drains, clk, rst, result_valid && !result_stall && !(adv && emit), !result_valid, "result taken but still valid")

endmodule
`default_nettype wire

// ===== rtl/core/escape_chain_text_encoder_top.sv =====
// An accepted item is written into a queue slot, then each result into the output register.
// Throughput: one result per cycle while the queue holds an item and result_stall is low;
// an item yields 1 to 6 results. The back-end sequencer that emits one byte per cycle sets
// that rate; the front takes an item every cycle while the queue has room.
// Reset (rst, synchronous): queue empty, no result held, chain state cleared, registers
// back to threshold 800 and line length 80.
`default_nettype none
module escape_chain_text_encoder_top import ectx_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_stall,
  input  item_t                  item_data,
  output logic                   result_valid,
  input  wire                    result_stall,
  output result_t                result_data,
  input  wire                    cfg_wr_en,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers; the user must write them only while the encoder is idle (not enforced).
  logic [11:0] space_threshold;
  logic [7:0]  line_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      space_threshold <= THRESHOLD_RESET;
      line_length     <= LINE_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SPACE_THRESHOLD: space_threshold <= cfg_wdata;
        REG_LINE_LENGTH:     line_length     <= cfg_wdata[7:0];
        default:             space_threshold <= space_threshold;
      endcase
    end
  end

  // Front: classify each byte into one or two padded bytes and push the transaction.
  logic        push;
  pad_entry_t  push_entry;
  logic        queue_full;

  ectx_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_data  (item_data),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue: decouple classification from the back end, which emits one byte per cycle unless stalled.
  logic        pop;
  queue_head_t head;

  ectx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head       (head)
  );

  // Back: chain-encode, then insert spaces and line feeds; hold results in an
  // output register. While a held result is stalled, the back end and the queue wait.
  ectx_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .space_threshold (space_threshold),
    .line_length     (line_length),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_data     (result_data)
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ectx_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 25;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  item_t                  item_data    = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result_data;
  logic                   cfg_wr_en    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata    = '0;

  // Byte stream still to be sent, and the encoder output still owed by the block.
  item_t   pending_items[$];
  result_t expected_bytes[$];

  // Encoder state mirrored on the testbench side.
  logic [7:0]  chain_prev     = 8'd0;
  logic        awaiting_start = 1'b1;
  logic [12:0] run_sum        = 13'd0;
  logic [7:0]  column         = 8'd0;
  logic [11:0] space_limit    = THRESHOLD_RESET;
  logic [7:0]  line_limit     = LINE_LENGTH_RESET;

  // Idle odds in percent per cycle; zero turns idling off.
  int send_idle_pct  = 25;
  int stall_idle_pct = 25;
  int send_gap       = 0;
  int stall_left     = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  escape_chain_text_encoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Work out every byte one accepted message byte produces: escape it, chain it
  // against the previous code, then add the space and line feed the running sum
  // and column count call for. The last byte of the run carries the end mark.
  task automatic encode_item(input item_t it);
    logic [7:0] pads[2];
    int         npads;
    logic [7:0] code;
    logic [7:0] enc;
    result_t    tail;
    if (it.first_of_message) begin
      chain_prev     = 8'd0;
      awaiting_start = 1'b1;
      run_sum        = 13'd0;
      column         = 8'd0;
    end
    npads = 2;
    if (it.data_byte == CH_SPACE) begin
      pads[0] = ~CH_UNDER;
      pads[1] = ~CH_UNDER;
    end else if (it.data_byte == CH_LF) begin
      pads[0] = ~CH_UNDER;
      pads[1] = ~CH_N;
    end else if (it.data_byte == CH_UNDER) begin
      pads[0] = ~CH_UNDER;
      pads[1] = ~CH_U;
    end else begin
      pads[0] = ~it.data_byte;
      pads[1] = 8'd0;
      npads   = 1;
    end
    for (int i = 0; i < npads; i++) begin
      code = pads[i];
      if (awaiting_start) begin
        enc            = code + FIRST_OFFSET;
        awaiting_start = 1'b0;
      end else if (code[7]) begin
        // Upper half: difference from the previous code, folded into 128..255.
        enc = {1'b1, 7'(code - chain_prev)};
      end else begin
        enc = {1'b0, 7'(chain_prev + code)};
      end
      chain_prev = enc;
      expected_bytes.push_back('{out_byte: enc, last_of_run: 1'b0});
      run_sum = run_sum + 13'(enc);
      if (run_sum >= 13'(space_limit)) begin
        expected_bytes.push_back('{out_byte: CH_SPACE, last_of_run: 1'b0});
        column  = column + 8'd1;
        run_sum = 13'd0;
      end
      if (column >= line_limit) begin
        expected_bytes.push_back('{out_byte: CH_LF, last_of_run: 1'b0});
        column = 8'd0;
      end
      column = column + 8'd1;
    end
    tail             = expected_bytes.pop_back();
    tail.last_of_run = 1'b1;
    expected_bytes.push_back(tail);
  endtask

  task automatic log_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected byte %02h last %0b, got byte %02h last %0b",
               $time, what, want.out_byte, want.last_of_run, got.out_byte, got.last_of_run);
  endtask

  task automatic queue_item(input logic [7:0] value, input logic first);
    item_t it;
    it.data_byte        = value;
    it.first_of_message = first;
    pending_items.push_back(it);
  endtask

  // Random bytes most of the time, with plenty of escapes and range edges.
  function automatic logic [7:0] pick_text_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 12) return CH_SPACE;
    if (roll < 20) return CH_LF;
    if (roll < 28) return CH_UNDER;
    if (roll < 34) return ($urandom_range(1) != 0) ? CH_N : CH_U;
    if (roll < 40) return ($urandom_range(1) != 0) ? 8'h00 : 8'hFF;
    if (roll < 46) return ($urandom_range(1) != 0) ? 8'h7F : 8'h80;
    return 8'($urandom);
  endfunction

  // Block until nothing is queued, driven or owed, then let the pipe drain.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_SPACE_THRESHOLD)
      space_limit = value;
    else
      line_limit = value[7:0];
  endtask

  task automatic begin_phase(input logic [11:0] thr, input logic [7:0] len,
                             input int send_pct, input int stall_pct);
    wait_idle();
    write_register(REG_SPACE_THRESHOLD, thr);
    write_register(REG_LINE_LENGTH, CFG_DATA_W'(len));
    send_idle_pct  = send_pct;
    stall_idle_pct = stall_pct;
  endtask

  // Driver: hold a stalled transaction, otherwise idle for a burst or present
  // the next queued byte. Predict at the edge that accepts the transaction.
  always @(posedge clk) begin : drive_items
    logic  next_valid;
    item_t next_data;
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = item_valid;
      next_data  = item_data;
      if (item_valid && !item_stall) begin
        encode_item(item_data);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() != 0) begin
          if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            send_gap = $urandom_range(0, 7);
          end else begin
            next_data  = pending_items.pop_front();
            next_valid = 1'b1;
          end
        end
      end
      item_valid <= next_valid;
      item_data  <= next_data;
    end
  end

  // Monitor: check each accepted result against the oldest expectation and
  // throw stall bursts at the output.
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_bytes.size() == 0) begin
          log_mismatch("unexpected result", '0, result_data);
        end else begin
          want = expected_bytes.pop_front();
          if (result_data.out_byte !== want.out_byte ||
              result_data.last_of_run !== want.last_of_run)
            log_mismatch("result mismatch", want, result_data);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (stall_idle_pct > 0 && $urandom_range(99) < stall_idle_pct) begin
        stall_left = $urandom_range(0, 7);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("escape_chain_text_encoder_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [11:0] thr;
    logic [7:0]  len;
    int          send_pct;
    int          stall_pct;
    int          sent;
    int          msg_len;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first byte after reset opens a message on its own,
    // range edges, all three escapes, and a message start on an escape.
    queue_item(8'h41, 1'b0);
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h7F, 1'b0);
    queue_item(8'h80, 1'b0);
    queue_item(CH_SPACE, 1'b0);
    queue_item(CH_LF, 1'b0);
    queue_item(CH_UNDER, 1'b0);
    queue_item(CH_N, 1'b0);
    queue_item(CH_U, 1'b0);
    queue_item(CH_SPACE, 1'b1);
    queue_item(8'hFF, 1'b1);
    queue_item(8'h00, 1'b0);

    // Zero threshold and zero line length: an escape expands to six bytes.
    begin_phase(12'd0, 8'd0, 25, 25);
    queue_item(CH_SPACE, 1'b1);
    queue_item(CH_LF, 1'b0);
    queue_item(CH_UNDER, 1'b0);
    queue_item(8'h55, 1'b0);

    // Top of both ranges, continuing the message across the change.
    begin_phase(12'd4095, 8'd255, 25, 25);
    queue_item(8'h01, 1'b0);
    queue_item(8'hFE, 1'b0);
    queue_item(CH_SPACE, 1'b0);

    // Smallest nonzero settings.
    begin_phase(12'd1, 8'd1, 25, 25);
    queue_item(8'hAA, 1'b1);
    queue_item(CH_UNDER, 1'b0);
    queue_item(8'h55, 1'b0);

    // Random phases: mostly well-formed messages of text-like bytes, some
    // loose bytes with a random start mark. The last phase runs idle-free.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          thr = 12'($urandom_range(100, 900));
          len = 8'($urandom_range(10, 80));
          send_pct = 30; stall_pct = 30;
        end
        1: begin
          thr = 12'd0; len = 8'd255; send_pct = 0; stall_pct = 0;
        end
        2: begin
          thr = 12'd4095; len = 8'd1; send_pct = 50; stall_pct = 15;
        end
        3: begin
          thr = 12'($urandom_range(0, 4095));
          len = 8'($urandom_range(0, 255));
          send_pct = 20; stall_pct = 50;
        end
        4: begin
          thr = 12'd1; len = 8'd0; send_pct = 35; stall_pct = 35;
        end
        default: begin
          thr = 12'($urandom_range(50, 600));
          len = 8'($urandom_range(2, 40));
          send_pct = 0; stall_pct = 0;
        end
      endcase
      begin_phase(thr, len, send_pct, stall_pct);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) begin
          msg_len = $urandom_range(1, 10);
          for (int k = 0; k < msg_len && sent < PHASE_ITEMS; k++) begin
            queue_item(pick_text_byte(), k == 0);
            sent++;
          end
        end else begin
          queue_item(8'($urandom), 1'($urandom));
          sent++;
        end
      end
    end

    wait_idle();
    if (mismatches == 0)
      $display("escape_chain_text_encoder_top verification clean");
    else
      $display("escape_chain_text_encoder_top verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ectx_pkg.sv
rtl/core/ectx_front.sv
rtl/core/ectx_queue.sv
rtl/core/ectx_back.sv
rtl/core/escape_chain_text_encoder_top.sv
verif/testbench.sv
